// ===== design/voa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voa_pkg
// Shared types and constants of the voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
package voa_pkg;

	localparam int NUM_VOICES = 32;
	localparam int ADDR_W     = $clog2(NUM_VOICES);
	localparam int VOICE_W    = 5;
	localparam int FRAME_W    = 32;
	localparam int MASK_W     = 32;
	localparam int OP_W       = 4;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index decoded from paddr[2]
	localparam logic REG_SOUND_EN = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC       = 4'd0,
		OP_PLAY        = 4'd1,
		OP_STOP        = 4'd2,
		OP_PAUSE       = 4'd3,
		OP_UNPAUSE     = 4'd4,
		OP_UNPAUSE_ALL = 4'd5,
		OP_STOP_ALL    = 4'd6,
		OP_TICK        = 4'd7,
		OP_QUERY       = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN,
		ST_DECIDE,
		ST_STEAL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic looping;
		logic paused;
		logic playing;
	} flags_t;

	typedef struct packed {
		logic [FRAME_W-1:0] stamp;
		flags_t             flags;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [VOICE_W-1:0] voice_index;
		logic               found;
		logic               stolen;
		logic               is_playing;
		logic               is_paused;
		logic               is_looping;
	} res_t;

	// operations that walk every voice
	function automatic logic is_bulk(input op_t op);
		is_bulk = op inside {OP_ALLOC, OP_UNPAUSE_ALL, OP_STOP_ALL, OP_TICK};
	endfunction

endpackage

// ===== design/voa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voa_if
// Valid/ready channels for commands and results of the voice allocator.
// ----------------------------------------------------------------------------
interface voa_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  operation;
	logic [4:0]  voice;
	logic        force_steal;
	logic        one_shot;
	logic [31:0] engine_playing_mask;

	modport source (
		output valid, operation, voice, force_steal, one_shot, engine_playing_mask,
		input  ready
	);
	modport sink (
		input  valid, operation, voice, force_steal, one_shot, engine_playing_mask,
		output ready
	);
endinterface

interface voa_res_if;
	logic       valid;
	logic       ready;
	logic [4:0] voice_index;
	logic       found;
	logic       stolen;
	logic       is_playing;
	logic       is_paused;
	logic       is_looping;

	modport source (
		output valid, voice_index, found, stolen, is_playing, is_paused, is_looping,
		input  ready
	);
	modport sink (
		input  valid, voice_index, found, stolen, is_playing, is_paused, is_looping,
		output ready
	);
endinterface

// ===== design/voa_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voa_cfg
// APB register slice holding the sound enable bit.
// ----------------------------------------------------------------------------
module voa_cfg import voa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  sound_enabled
);

	logic sound_enabled_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SOUND_EN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_enabled_q <= 1'b1;
		end else if (wr_en) begin
			sound_enabled_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SOUND_EN) begin
			prdata[0] = sound_enabled_q;
		end
	end

	assign sound_enabled = sound_enabled_q;

endmodule

// ===== design/voa_voice_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voa_voice_ram
// Per-voice state memory (stamp and flags), one read and one write port,
// registered read data. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module voa_voice_ram import voa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t                mem_q [NUM_VOICES];
	logic [NUM_VOICES-1:0] vld_q;
	entry_t                rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// ===== design/voa_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voa_seq
// Operation sequencer: walks the voice memory one entry a cycle, modifies and
// writes back, tracks the first free and the oldest non-paused voice.
// ----------------------------------------------------------------------------
module voa_seq import voa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sound_enabled,
	voa_cmd_if.sink  cmd,
	output mem_req_t mem_req,
	input  entry_t   mem_rd,
	output logic     rsp_vld,
	output res_t     rsp,
	input  logic     rsp_take
);

	state_t             state_q, state_d;
	op_t                op_q;
	logic [VOICE_W-1:0] voice_q;
	logic               force_q;
	logic               one_shot_q;
	logic [MASK_W-1:0]  mask_q;
	logic [FRAME_W-1:0] frame_q;
	logic [ADDR_W-1:0]  cnt_q;
	logic               rd_vld_s1;
	logic [ADDR_W-1:0]  rd_addr_s1;
	flags_t             vflags_q;
	logic               free_got_q;
	logic [ADDR_W-1:0]  free_idx_q;
	flags_t             free_flags_q;
	logic               best_have_q;
	logic [ADDR_W-1:0]  best_idx_q;
	logic [FRAME_W-1:0] best_stamp_q;
	flags_t             best_flags_q;
	res_t               res_q;

	logic               accept;
	op_t                op_in;
	logic               in_range_in;
	logic               in_range_q;
	logic               last_rd;
	flags_t             nf;
	logic [FRAME_W-1:0] ns;
	logic               pwr;
	logic [MASK_W-1:0]  msh;
	logic               engine;
	logic               is_free;
	logic               is_older;

	assign op_in       = op_t'(cmd.operation);
	assign in_range_in = int'(cmd.voice) < NUM_VOICES;
	assign in_range_q  = int'(voice_q) < NUM_VOICES;
	assign accept      = cmd.valid && cmd.ready;
	assign last_rd     = !is_bulk(op_q) || (cnt_q == ADDR_W'(NUM_VOICES - 1));

	// modify stage on the entry read in the previous cycle
	always_comb begin
		nf     = mem_rd.flags;
		ns     = mem_rd.stamp;
		pwr    = 1'b0;
		msh    = mask_q >> rd_addr_s1;
		engine = msh[0];
		case (op_q)
			OP_PLAY: begin
				nf  = '{looping: !one_shot_q, paused: 1'b0, playing: 1'b1};
				ns  = frame_q;
				pwr = 1'b1;
			end
			OP_STOP: begin
				nf.playing = 1'b0;
				nf.paused  = 1'b0;
				pwr        = 1'b1;
			end
			OP_PAUSE: begin
				nf.paused = 1'b1;
				pwr       = 1'b1;
			end
			OP_UNPAUSE, OP_UNPAUSE_ALL: begin
				nf.paused = 1'b0;
				pwr       = 1'b1;
			end
			OP_STOP_ALL: begin
				if (mem_rd.flags.playing) begin
					nf.playing = 1'b0;
					nf.paused  = 1'b0;
				end
				pwr = 1'b1;
			end
			OP_TICK: begin
				if (mem_rd.flags.playing && !engine) begin
					nf.playing = 1'b0;
				end
				pwr = 1'b1;
			end
			default: begin
				pwr = 1'b0;
			end
		endcase
		is_free  = !mem_rd.flags.playing && !mem_rd.flags.paused;
		is_older = !mem_rd.flags.paused && (!best_have_q || (mem_rd.stamp < best_stamp_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!sound_enabled) begin
						state_d = ST_RESP;
					end else if (!is_bulk(op_in) && !in_range_in) begin
						state_d = ST_DECIDE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (op_q == OP_ALLOC && !free_got_q && force_q && best_have_q) begin
					state_d = ST_STEAL;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_STEAL: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		rsp_vld   = (state_q == ST_RESP);
		rsp       = res_q;
		mem_req   = '0;
		if (state_q == ST_SCAN) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = is_bulk(op_q) ? cnt_q : ADDR_W'(voice_q);
		end
		if (rd_vld_s1 && pwr) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = rd_addr_s1;
			mem_req.wr_data = '{stamp: ns, flags: nf};
		end
		if (state_q == ST_STEAL) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = best_idx_q;
			mem_req.wr_data = '{stamp: best_stamp_q,
				flags: '{looping: best_flags_q.looping, paused: 1'b0, playing: 1'b0}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			frame_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_DECIDE && op_q == OP_TICK) begin
				frame_q <= frame_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_req.rd_addr;
		case (state_q)
			ST_IDLE: begin
				op_q         <= op_in;
				voice_q      <= cmd.voice;
				force_q      <= cmd.force_steal;
				one_shot_q   <= cmd.one_shot;
				mask_q       <= cmd.engine_playing_mask;
				cnt_q        <= '0;
				vflags_q     <= '0;
				free_got_q   <= 1'b0;
				best_have_q  <= 1'b0;
				// disabled: report nothing, echo the voice unless allocating
				res_q <= '{voice_index: (op_in == OP_ALLOC) ? VOICE_W'(0) : cmd.voice,
					found: 1'b0, stolen: 1'b0, is_playing: 1'b0, is_paused: 1'b0,
					is_looping: 1'b0};
			end
			ST_SCAN: begin
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DECIDE: begin
				if (op_q != OP_ALLOC) begin
					res_q <= '{voice_index: voice_q, found: 1'b0, stolen: 1'b0,
						is_playing: vflags_q.playing, is_paused: vflags_q.paused,
						is_looping: vflags_q.looping};
				end else if (free_got_q) begin
					res_q <= '{voice_index: VOICE_W'(free_idx_q), found: 1'b1, stolen: 1'b0,
						is_playing: free_flags_q.playing, is_paused: free_flags_q.paused,
						is_looping: free_flags_q.looping};
				end else begin
					res_q <= '0;
				end
			end
			ST_STEAL: begin
				res_q <= '{voice_index: VOICE_W'(best_idx_q), found: 1'b1, stolen: 1'b1,
					is_playing: 1'b0, is_paused: 1'b0, is_looping: best_flags_q.looping};
			end
			default: begin
			end
		endcase
		if (rd_vld_s1) begin
			if (in_range_q && rd_addr_s1 == ADDR_W'(voice_q)) begin
				vflags_q <= nf;
			end
			if (op_q == OP_ALLOC) begin
				if (is_free && !free_got_q) begin
					free_got_q   <= 1'b1;
					free_idx_q   <= rd_addr_s1;
					free_flags_q <= mem_rd.flags;
				end
				if (is_older) begin
					best_have_q  <= 1'b1;
					best_idx_q   <= rd_addr_s1;
					best_stamp_q <= mem_rd.stamp;
					best_flags_q <= mem_rd.flags;
				end
			end
		end
	end

endmodule

// ===== design/voice_allocator_oldest_steal_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_top
// Voice allocator with oldest-voice stealing, per-voice flags and frame stamps.
// ----------------------------------------------------------------------------
// Commands enter on the cmd channel (valid/ready), one result per command
// leaves on the res channel. The APB port holds the sound enable register at
// byte address 0; while it is zero each command goes straight to the response
// state and is answered with nothing found and no state change.
// Per-voice flags and start stamps live in one memory with a registered read.
// Single-voice commands (play, stop, pause, unpause, query and unused codes)
// read their one entry before the result is formed. Allocate, unpause-all,
// stop-all and frame tick walk all NUM_VOICES entries through the single read
// port; an allocate that steals a voice passes an extra steal state before its
// result.
// One command is worked on at a time; the next one can transfer once the
// sequencer is back in idle after the previous result enters the output
// register. A stalled receiver leaves one result in the output register
// and one in the sequencer, after which the cmd channel is held off.
// Reset clears all voice flags, stamps and the frame counter at once (per-entry
// valid bits) and sets sound enable; no clearing pass is needed.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal_top import voa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	voa_cmd_if.sink               cmd,
	voa_res_if.source             res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic     sound_enabled;
	mem_req_t mem_req;
	entry_t   mem_rd;
	logic     rsp_vld;
	res_t     rsp;
	logic     rsp_take;
	logic     out_vld_q;
	res_t     out_q;

	voa_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sound_enabled (sound_enabled)
	);

	voa_voice_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

	voa_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.sound_enabled (sound_enabled),
		.cmd           (cmd),
		.mem_req       (mem_req),
		.mem_rd        (mem_rd),
		.rsp_vld       (rsp_vld),
		.rsp           (rsp),
		.rsp_take      (rsp_take)
	);

	// output register frees up in the same cycle it transfers
	assign rsp_take = !out_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_take) begin
			out_vld_q <= rsp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take && rsp_vld) begin
			out_q <= rsp;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.voice_index = out_q.voice_index;
	assign res.found       = out_q.found;
	assign res.stolen      = out_q.stolen;
	assign res.is_playing  = out_q.is_playing;
	assign res.is_paused   = out_q.is_paused;
	assign res.is_looping  = out_q.is_looping;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voice allocator with oldest-voice stealing.
// ----------------------------------------------------------------------------
// Commands are sent as valid/ready transfers with random source gaps and
// random receiver stalls. A behavioral copy of the voice table (flags, start
// stamps, frame counter, sound enable) predicts each result, and every result
// field is compared in order. Sound enable is written and read back over APB
// only while nothing is in flight.
// ----------------------------------------------------------------------------
module testbench;
	import voa_pkg::*;

	localparam int          CYCLE_LIMIT  = 600000;
	localparam int          DRAIN_CYCLES = 64;
	localparam logic [3:0]  OP_RSVD_LO   = 4'd9;
	localparam logic [3:0]  OP_RSVD_HI   = 4'd15;
	localparam logic [31:0] ALL_VOICES   = 32'hffff_ffff;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic                  pready;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;

	voa_cmd_if cmd_ch();
	voa_res_if res_ch();

	voice_allocator_oldest_steal_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predicted voice table
	flags_t             voice_state [NUM_VOICES];
	logic [FRAME_W-1:0] start_stamp [NUM_VOICES];
	logic [FRAME_W-1:0] frame_ctr;
	logic               sound_en;

	res_t pending_results [$];
	res_t last_exp;

	int src_idle_pct    = 0;
	int sink_stall_pct  = 0;
	int cmds_sent       = 0;
	int disabled_cmds   = 0;
	int results_checked = 0;
	int steals_seen     = 0;
	int alloc_misses    = 0;
	int err_cnt         = 0;
	int cycle_cnt       = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t predict_voice_op(input logic [3:0] op, input logic [4:0] v,
		input logic force_steal, input logic one_shot, input logic [31:0] mask);
		res_t               r;
		flags_t             f;
		logic               got;
		logic               have;
		logic [FRAME_W-1:0] best;
		logic [VOICE_W-1:0] idx;
		r = '0;
		f = '0;
		got = 1'b0;
		have = 1'b0;
		best = '0;
		idx = '0;
		r.voice_index = v;
		if (!sound_en) begin
			if (op == OP_ALLOC)
				r.voice_index = '0;
			disabled_cmds++;
		end else begin
			case (op)
				OP_ALLOC: begin
					for (int s = 0; s < NUM_VOICES; s++)
						if (!got && !voice_state[s].playing && !voice_state[s].paused) begin
							idx = VOICE_W'(s);
							got = 1'b1;
						end
					// nothing free: oldest non-paused voice, lowest index on equal stamps
					if (!got && force_steal) begin
						for (int s = 0; s < NUM_VOICES; s++)
							if (!voice_state[s].paused && (!have || start_stamp[s] < best)) begin
								best = start_stamp[s];
								idx = VOICE_W'(s);
								have = 1'b1;
							end
						if (have) begin
							voice_state[idx].playing = 1'b0;
							voice_state[idx].paused  = 1'b0;
							got = 1'b1;
							r.stolen = 1'b1;
							steals_seen++;
						end
					end
					if (got) begin
						r.found = 1'b1;
						f = voice_state[idx];
					end else begin
						alloc_misses++;
					end
					r.voice_index = idx;
				end
				OP_PLAY: begin
					voice_state[v] = '{looping: ~one_shot, paused: 1'b0, playing: 1'b1};
					start_stamp[v] = frame_ctr;
				end
				OP_STOP: begin
					voice_state[v].playing = 1'b0;
					voice_state[v].paused  = 1'b0;
				end
				OP_PAUSE:   voice_state[v].paused = 1'b1;
				OP_UNPAUSE: voice_state[v].paused = 1'b0;
				OP_UNPAUSE_ALL: begin
					for (int s = 0; s < NUM_VOICES; s++)
						voice_state[s].paused = 1'b0;
				end
				OP_STOP_ALL: begin
					// paused voices that are not playing keep their pause
					for (int s = 0; s < NUM_VOICES; s++)
						if (voice_state[s].playing) begin
							voice_state[s].playing = 1'b0;
							voice_state[s].paused  = 1'b0;
						end
				end
				OP_TICK: begin
					for (int s = 0; s < NUM_VOICES; s++)
						if (!mask[s])
							voice_state[s].playing = 1'b0;
					frame_ctr = frame_ctr + 1'b1;
				end
				default: ;
			endcase
			if (op != OP_ALLOC)
				f = voice_state[v];
		end
		r.is_playing = f.playing;
		r.is_paused  = f.paused;
		r.is_looping = f.looping;
		return r;
	endfunction

	task automatic issue(input logic [3:0] op, input logic [4:0] v, input logic force_steal,
		input logic one_shot, input logic [31:0] mask);
		if ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		cmd_ch.valid               <= 1'b1;
		cmd_ch.operation           <= op;
		cmd_ch.voice               <= v;
		cmd_ch.force_steal         <= force_steal;
		cmd_ch.one_shot            <= one_shot;
		cmd_ch.engine_playing_mask <= mask;
		do @(posedge clk); while (!cmd_ch.ready);
		last_exp = predict_voice_op(op, v, force_steal, one_shot, mask);
		pending_results = {pending_results, last_exp};
		cmds_sent++;
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sound_enable(input logic en);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_SOUND_EN, 2'b00};
		pwdata  <= {31'($urandom), en};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sound_en = en;
		// read back, setup phase follows the write access directly
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== en) begin
			$display("%0t: sound_enabled readback mismatch, expected %0d, actual %0d",
				$time, en, prdata[0]);
			err_cnt++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [VOICE_W-1:0] want,
		input logic [VOICE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// sample at the rising edge, compare at the falling edge once the sender has logged its transfer
	always begin : result_check
		res_t got;
		res_t want;
		logic took;
		@(posedge clk);
		took = (res_ch.valid === 1'b1) && (res_ch.ready === 1'b1);
		got = '{voice_index: res_ch.voice_index, found: res_ch.found, stolen: res_ch.stolen,
			is_playing: res_ch.is_playing, is_paused: res_ch.is_paused,
			is_looping: res_ch.is_looping};
		@(negedge clk);
		if (took) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				check_field("voice_index", want.voice_index, got.voice_index);
				check_field("found", VOICE_W'(want.found), VOICE_W'(got.found));
				check_field("stolen", VOICE_W'(want.stolen), VOICE_W'(got.stolen));
				check_field("is_playing", VOICE_W'(want.is_playing), VOICE_W'(got.is_playing));
				check_field("is_paused", VOICE_W'(want.is_paused), VOICE_W'(got.is_paused));
				check_field("is_looping", VOICE_W'(want.is_looping), VOICE_W'(got.is_looping));
				results_checked++;
			end
		end
	end

	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		issue(OP_QUERY, 5'd0, 1'b0, 1'b0, '0);
		issue(OP_ALLOC, 5'd31, 1'b0, 1'b1, '0);
		issue(OP_PLAY, 5'd0, 1'b1, 1'b0, '0);
		issue(OP_PLAY, 5'd31, 1'b0, 1'b1, ALL_VOICES);
		issue(OP_ALLOC, 5'd0, 1'b1, 1'b0, '0);
		issue(OP_PAUSE, 5'd0, 1'b0, 1'b0, '0);
		issue(OP_QUERY, 5'd0, 1'b1, 1'b1, ALL_VOICES);
		issue(OP_UNPAUSE, 5'd0, 1'b0, 1'b0, '0);
		issue(OP_PAUSE, 5'd31, 1'b0, 1'b0, '0);
		issue(OP_UNPAUSE_ALL, 5'd31, 1'b0, 1'b0, '0);
		issue(OP_PAUSE, 5'd0, 1'b0, 1'b0, '0);
		issue(OP_STOP, 5'd31, 1'b0, 1'b0, '0);
		issue(OP_PAUSE, 5'd5, 1'b0, 1'b0, '0);
		// voice 5 is paused but idle, so stop all leaves its pause
		issue(OP_STOP_ALL, 5'd5, 1'b0, 1'b0, '0);
		issue(OP_QUERY, 5'd0, 1'b0, 1'b0, '0);
		issue(OP_PLAY, 5'd3, 1'b0, 1'b0, '0);
		issue(OP_TICK, 5'd3, 1'b0, 1'b0, ALL_VOICES);
		issue(OP_TICK, 5'd3, 1'b1, 1'b1, '0);
		issue(OP_PLAY, 5'd3, 1'b1, 1'b1, '0);
		issue(OP_RSVD_LO, 5'd3, 1'b1, 1'b1, ALL_VOICES);
		issue(OP_RSVD_HI, 5'd5, 1'b0, 1'b0, ALL_VOICES);
		issue(OP_ALLOC, 5'd7, 1'b1, 1'b1, ALL_VOICES);
		issue(OP_UNPAUSE, 5'd5, 1'b1, 1'b0, '0);
	endtask

	// every voice paused: a forced allocate must not steal
	task automatic test_all_paused();
		for (int v = 0; v < NUM_VOICES; v++)
			issue(OP_PAUSE, 5'(v), 1'($urandom), 1'($urandom), $urandom);
		issue(OP_ALLOC, 5'($urandom), 1'b1, 1'($urandom), $urandom);
		issue(OP_ALLOC, 5'($urandom), 1'b0, 1'($urandom), $urandom);
		issue(OP_UNPAUSE, 5'd7, 1'($urandom), 1'($urandom), $urandom);
		issue(OP_ALLOC, 5'($urandom), 1'b1, 1'($urandom), $urandom);
		issue(OP_PLAY, 5'd7, 1'($urandom), 1'b0, $urandom);
		issue(OP_ALLOC, 5'($urandom), 1'b1, 1'($urandom), $urandom);
		issue(OP_UNPAUSE_ALL, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
	endtask

	task automatic test_traffic(input int src_pct, input int sink_pct, input int n);
		int          stop_at;
		int          scene;
		int          k;
		logic [31:0] mask;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		stop_at = cmds_sent + n;
		while (cmds_sent < stop_at) begin
			scene = $urandom_range(9);
			if (scene <= 5) begin
				// one game frame: allocate-and-play pairs among single-voice commands
				k = $urandom_range(1, 10);
				repeat (k) begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5, 6: begin
							issue(OP_ALLOC, 5'($urandom), $urandom_range(3) != 0,
								1'($urandom), $urandom);
							if (last_exp.found)
								issue(OP_PLAY, last_exp.voice_index, 1'($urandom),
									1'($urandom), $urandom);
						end
						7: issue(OP_PAUSE, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
						8: issue(OP_UNPAUSE, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
						default: begin
							if ($urandom_range(1))
								issue(OP_STOP, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
							else
								issue(OP_QUERY, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
						end
					endcase
				end
				// mostly keep voices alive so the table fills and steals happen
				case ($urandom_range(9))
					0:       mask = $urandom;
					1, 2:    mask = $urandom | $urandom | $urandom;
					default: mask = ALL_VOICES;
				endcase
				issue(OP_TICK, 5'($urandom), 1'($urandom), 1'($urandom), mask);
			end else if (scene == 6) begin
				if ($urandom_range(3) == 0) begin
					for (int v = 0; v < NUM_VOICES; v++)
						issue(OP_PAUSE, 5'(v), 1'($urandom), 1'($urandom), $urandom);
				end else begin
					repeat ($urandom_range(8, NUM_VOICES))
						issue(OP_PAUSE, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
				end
				issue(OP_ALLOC, 5'($urandom), 1'b1, 1'($urandom), $urandom);
				if ($urandom_range(1))
					issue(OP_UNPAUSE_ALL, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
			end else if (scene == 7) begin
				if ($urandom_range(1))
					issue(OP_STOP_ALL, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
				else
					issue(OP_UNPAUSE_ALL, 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
				if ($urandom_range(3) == 0)
					wait_drained();
			end else begin
				issue(4'($urandom_range(15)), 5'($urandom), 1'($urandom), 1'($urandom),
					$urandom);
			end
		end
	endtask

	task automatic test_disabled();
		wait_drained();
		write_sound_enable(1'b0);
		repeat (48)
			issue(4'($urandom_range(15)), 5'($urandom), 1'($urandom), 1'($urandom), $urandom);
		wait_drained();
		write_sound_enable(1'b1);
	endtask

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
			pending_results.size());
		$display("FAIL voice_allocator_oldest_steal_top");
		$finish;
	end

	initial begin
		arst_n                     <= 1'b0;
		cmd_ch.valid               <= 1'b0;
		cmd_ch.operation           <= '0;
		cmd_ch.voice               <= '0;
		cmd_ch.force_steal         <= 1'b0;
		cmd_ch.one_shot            <= 1'b0;
		cmd_ch.engine_playing_mask <= '0;
		psel                       <= 1'b0;
		penable                    <= 1'b0;
		pwrite                     <= 1'b0;
		paddr                      <= '0;
		pwdata                     <= '0;
		for (int s = 0; s < NUM_VOICES; s++) begin
			voice_state[s] = '0;
			start_stamp[s] = '0;
		end
		frame_ctr = '0;
		sound_en  = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_sound_enable(1'b1);
		test_directed();
		test_all_paused();
		test_traffic(0, 0, 310);
		test_traffic(68, 0, 310);
		test_disabled();
		test_traffic(0, 68, 310);
		test_traffic(28, 28, 310);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d commands sent (%0d with sound disabled), %0d results checked",
			cmds_sent, disabled_cmds, results_checked);
		$display("%0d voices stolen, %0d allocations found no voice", steals_seen,
			alloc_misses);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("PASS voice_allocator_oldest_steal_top");
		end else begin
			$display("FAIL voice_allocator_oldest_steal_top");
		end
		$finish;
	end

endmodule
